>>> hw/rtl/slirm_pkg.sv
// ----------------------------------------------------------------------------
// slirm_pkg: shared types and codes of the sorted key list
// Command broadcast to the cell row, neighbor link, function and status codes.
// ----------------------------------------------------------------------------
package slirm_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned OccWidth = 7;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic signed [KeyWidth-1:0] key;
  } cell_cmd_t;

  typedef struct packed {
    logic                       valid;
    logic                       place;
    logic signed [KeyWidth-1:0] key;
  } cell_link_t;

endpackage

>>> hw/rtl/sorted_list_insert_remove_min_core.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_min_core: bounded sorted key list
// Keeps up to CAPACITY signed keys in ascending order in a row of cells.
//
// Input channel (in_valid_i / in_ready_o): func_i selects insert of key_i or
// removal of the smallest held key. Output channel (out_valid_o / out_ready_i):
// one result per item with removed_key_o, status_o and occupancy_o.
// Every cell compares its key with the broadcast key in the same cycle and
// shifts toward its neighbor, so the result is registered and appears in the
// cycle after acceptance; one item per cycle is sustained while not stalled.
// The single output register sets the rate; input is taken whenever that
// register is empty or being drained in the same cycle. When the receiver
// stalls, the result holds and the input side stalls behind it.
// Insert on a full list and remove on an empty list leave the list unchanged
// and report status full or empty. Reset empties the list and the output.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_min_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  func_i,
  input  logic signed [slirm_pkg::KeyWidth-1:0] key_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [slirm_pkg::KeyWidth-1:0] removed_key_o,
  output logic [1:0]                            status_o,
  output logic [slirm_pkg::OccWidth-1:0]        occupancy_o
);
  import slirm_pkg::*;

  localparam int unsigned CntWidth = $clog2(CAPACITY + 1);
  localparam logic [CntWidth-1:0] CapCount = CntWidth'(CAPACITY);

  logic                       accept;
  logic                       full, empty;
  logic [CntWidth-1:0]        count_q, count_d;
  cell_cmd_t                  cmd;
  cell_link_t                 link [CAPACITY];
  cell_link_t                 head_link, tail_link;

  logic                       out_valid_q;
  logic signed [KeyWidth-1:0] removed_key_q, removed_key_d;
  logic [1:0]                 status_q, status_d;
  logic [CntWidth+OccWidth-1:0] occ_ext;
  logic [OccWidth-1:0]        occupancy_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CapCount);
  assign empty      = (count_q == '0);

  assign cmd.ins = accept && (func_i == FUNC_INSERT) && !full;
  assign cmd.rem = accept && (func_i == FUNC_REMOVE) && !empty;
  assign cmd.key = key_i;

  assign head_link = '{valid: 1'b1, place: 1'b0, key: '0};
  assign tail_link = '{valid: 1'b0, place: 1'b1, key: '0};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    slirm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .prev_i ((g == 0) ? head_link : link[(g == 0) ? 0 : g - 1]),
      .next_i ((g == CAPACITY - 1) ? tail_link
                                   : link[(g == CAPACITY - 1) ? g : g + 1]),
      .link_o (link[g])
    );
  end

  always_comb begin
    count_d       = count_q;
    removed_key_d = '0;
    status_d      = STATUS_OK;
    if (func_i == FUNC_INSERT) begin
      if (full) begin
        status_d = STATUS_FULL;
      end else begin
        count_d = count_q + CntWidth'(1);
      end
    end else begin
      if (empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        count_d       = count_q - CntWidth'(1);
        removed_key_d = link[0].key;
      end
    end
  end

  assign occ_ext = {{OccWidth{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_key_q <= removed_key_d;
      status_q      <= status_d;
      occupancy_q   <= occ_ext[OccWidth-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign removed_key_o = removed_key_q;
  assign status_o      = status_q;
  assign occupancy_o   = occupancy_q;

endmodule

>>> hw/rtl/slirm_cell.sv
// ----------------------------------------------------------------------------
// slirm_cell: one slot of the sorted key list
// Holds one key and its valid bit, compares against the broadcast key and
// shifts right on insert or left on remove.
// ----------------------------------------------------------------------------
module slirm_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slirm_pkg::cell_cmd_t  cmd_i,
  input  slirm_pkg::cell_link_t prev_i,
  input  slirm_pkg::cell_link_t next_i,
  output slirm_pkg::cell_link_t link_o
);
  import slirm_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [KeyWidth-1:0] key_q, key_d;
  logic                       place;

  assign place = !valid_q || !(key_q < cmd_i.key);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (cmd_i.ins) begin
      valid_d = valid_q || prev_i.valid;
      if (place && prev_i.place) begin
        key_d = prev_i.key;
      end else if (place) begin
        key_d = cmd_i.key;
      end
    end else if (cmd_i.rem) begin
      valid_d = next_i.valid;
      key_d   = next_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign link_o = '{valid: valid_q, place: place, key: key_q};

endmodule
